### hdl/single_float_add_sub_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the single float add/sub core
// Checks compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SINGLE_FLOAT_ADD_SUB_CORE_MACROS_SVH
`define SINGLE_FLOAT_ADD_SUB_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SFAS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SFAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SFAS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SFAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/sfas_pkg.sv
// ---------------------------------------------------------------------------
// sfas_pkg
// Types and constants shared by the float add/sub core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package sfas_pkg;
  localparam logic [22:0] FRAC_MASK = 23'h7FFFFF;
  localparam logic [7:0]  EXP_INF   = 8'hFF;

  typedef struct packed {
    logic        req_type;
    logic [31:0] a_bits;
    logic [31:0] b_bits;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        overflow;
    logic        underflow;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic align;
    logic combine;
    logic norm;
    logic pack;
  } sfas_cmd_t;

  typedef struct packed {
    logic norm_done;
  } sfas_sts_t;
endpackage

### hdl/sfas_datapath.sv
// ---------------------------------------------------------------------------
// sfas_datapath
// Align, combine, normalize and pack steps under controller command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "single_float_add_sub_core_macros.svh"
module sfas_datapath
  import sfas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sfas_cmd_t cmd,
  output sfas_sts_t sts,
  input  in_word_t  in_word,
  output out_word_t out_word
);
  logic        sa, sb, sign;
  logic [7:0]  ea, eb;
  logic [23:0] fa, fb;
  logic [24:0] mag;
  logic signed [9:0] exp;
  logic [4:0]  lz;
  logic [4:0]  sh;
  logic [8:0]  diff;
  logic [24:0] mag_shl;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) lz = 5'(23 - i);
    end
    mag_shl = mag << lz;
  end

  always_comb begin
    diff = (ea > eb) ? ({1'b0, ea} - {1'b0, eb}) : ({1'b0, eb} - {1'b0, ea});
    sh = (diff >= 9'd25) ? 5'd25 : diff[4:0];
  end

  assign sts.norm_done = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sa <= in_word.a_bits[31];
      sb <= in_word.b_bits[31] ^ in_word.req_type;
      ea <= in_word.a_bits[30:23];
      eb <= in_word.b_bits[30:23];
      fa <= {1'b1, in_word.a_bits[22:0]};
      fb <= {1'b1, in_word.b_bits[22:0]};
    end
    if (cmd.align) begin
      if (ea > eb) begin
        fb  <= (sh == 5'd25) ? 24'd0 : fb >> sh;
        exp <= 10'(ea);
      end else begin
        fa  <= (sh == 5'd25) ? 24'd0 : fa >> sh;
        exp <= 10'(eb);
      end
    end
    if (cmd.combine) begin
      if (sa == sb) begin
        mag <= {1'b0, fa} + {1'b0, fb};
        sign <= sa;
      end else if (fa > fb) begin
        mag <= {1'b0, fa - fb};
        sign <= sa;
      end else begin
        mag <= {1'b0, fb - fa};
        sign <= sb;
      end
    end
    if (cmd.norm && mag != 25'd0) begin
      if (mag[24]) begin
        mag <= mag >> 1;
        exp <= exp + 10'sd1;
      end else begin
        mag <= mag_shl;
        exp <= exp - 10'(lz);
      end
    end
    if (rst) begin
      out_word <= '0;
    end else if (cmd.pack) begin
      out_word.overflow  <= 1'b0;
      out_word.underflow <= 1'b0;
      if (mag == 25'd0) begin
        out_word.result_bits <= 32'd0;
      end else if (exp > 10'sd254) begin
        out_word.result_bits <= {sign, EXP_INF, 23'd0};
        out_word.overflow    <= 1'b1;
      end else if (exp < 10'sd1) begin
        out_word.result_bits <= {sign, 31'd0};
        out_word.underflow   <= 1'b1;
      end else begin
        out_word.result_bits <= {sign, exp[7:0], mag[22:0] & FRAC_MASK};
      end
    end
  end

  `SFAS_ASSERT_IMPL(a_flags_excl, clk, rst, 1'b1, !(out_word.overflow && out_word.underflow))
  `SFAS_ASSERT_NEXT(a_norm_top, clk, rst, cmd.norm && mag != 25'd0, mag[23] && !mag[24])
  `SFAS_ASSERT_IMPL(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))
endmodule

### hdl/sfas_ctrl.sv
// ---------------------------------------------------------------------------
// sfas_ctrl
// Sequences load, align, combine, normalize, pack and output handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "single_float_add_sub_core_macros.svh"
module sfas_ctrl
  import sfas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  sfas_sts_t sts,
  output sfas_cmd_t cmd
);
  typedef enum logic [2:0] {IDLE, ALIGN, COMB, NORM, PACK, DONE} state_t;
  state_t state;

  assign in_stall = !(state == IDLE || (state == DONE && !out_stall));
  assign out_valid = (state == DONE);

  always_comb begin
    cmd = '0;
    cmd.load    = in_valid && !in_stall;
    cmd.align   = (state == ALIGN);
    cmd.combine = (state == COMB);
    cmd.norm    = (state == NORM);
    cmd.pack    = (state == PACK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:  if (in_valid) state <= ALIGN;
        ALIGN: state <= COMB;
        COMB:  state <= NORM;
        NORM:  if (sts.norm_done) state <= PACK;
        PACK:  state <= DONE;
        DONE:  if (!out_stall) state <= in_valid ? ALIGN : IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  `SFAS_ASSERT_NEXT(a_pack_done, clk, rst, state == PACK, state == DONE)
  `SFAS_ASSERT_IMPL(a_no_load_busy, clk, rst, cmd.load, state == IDLE || state == DONE)
  `SFAS_ASSERT_NEXT(a_load_align, clk, rst, cmd.load, state == ALIGN)
endmodule

### hdl/single_float_add_sub_core.sv
// Single-precision add/subtract with truncation. One word at a time: an
// accepted word passes through the align, combine, normalize and pack
// states before its result is offered, as set by the controller sequence;
// a new word is taken in the cycle its predecessor's result is taken.
// ---------------------------------------------------------------------------
// single_float_add_sub_core
// Top level: controller plus datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module single_float_add_sub_core
  import sfas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);
  sfas_cmd_t cmd;
  sfas_sts_t sts;

  sfas_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  sfas_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_word(in_data), .out_word(out_data)
  );
endmodule
